/* rtl/duration_text_parser_assert.svh */
// assertion macros for the duration text parser checks
`ifndef DURATION_TEXT_PARSER_ASSERT_SVH
`define DURATION_TEXT_PARSER_ASSERT_SVH

// same-cycle implication
`define DTP_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("duration_text_parser check failed");

// next-cycle implication
`define DTP_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("duration_text_parser check failed");

`endif

/* rtl/dtp_pkg.sv */
package dtp_pkg;

	typedef enum logic [3:0] {
		PH_START  = 4'b0001,
		PH_TERM   = 4'b0010,
		PH_SIGN   = 4'b0100,
		PH_DIGITS = 4'b1000
	} dtp_phase_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_EMPTY  = 3'd1,
		ST_DIGIT  = 3'd2,
		ST_UNIT   = 3'd3,
		ST_BOUNDS = 3'd4
	} dtp_status_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_W     = 8'h77;

	localparam int TERM_W  = 63;
	localparam int TOTAL_W = 64;
	localparam int SCALE_W = 14;

	localparam logic [SCALE_W-1:0] SCALE_M = SCALE_W'(1);
	localparam logic [SCALE_W-1:0] SCALE_H = SCALE_W'(60);
	localparam logic [SCALE_W-1:0] SCALE_D = SCALE_W'(60 * 24);
	localparam logic [SCALE_W-1:0] SCALE_W_MIN = SCALE_W'(60 * 24 * 7);

	localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [TERM_W-1:0] LIM_M = TERM_W'(MAX64);
	localparam logic [TERM_W-1:0] LIM_H = TERM_W'(MAX64 / 64'd60);
	localparam logic [TERM_W-1:0] LIM_D = TERM_W'(MAX64 / 64'd1440);
	localparam logic [TERM_W-1:0] LIM_W = TERM_W'(MAX64 / 64'd10080);

	typedef struct packed {
		logic              vld;
		logic              neg;
		logic [TERM_W-1:0] prod;
	} dtp_add_req_t;

	typedef struct packed {
		logic               ovf;
		logic [TOTAL_W-1:0] total;
	} dtp_acc_t;

endpackage

/* rtl/dtp_in_if.sv */
interface dtp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

/* rtl/dtp_out_if.sv */
interface dtp_out_if;
	logic              valid;
	logic              ready;
	logic signed [63:0] total_minutes;
	logic [2:0]        status;

	modport source (output valid, output total_minutes, output status, input ready);
	modport sink (input valid, input total_minutes, input status, output ready);
endinterface

/* rtl/dtp_accum.sv */
module dtp_accum import dtp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         clr,
	input  dtp_add_req_t req,
	output dtp_acc_t     acc
);

	logic [TOTAL_W-1:0] total_q;
	logic               pend_q;
	logic               pend_neg_q;
	logic [TERM_W-1:0]  pend_prod_q;
	logic [TOTAL_W:0]   sum;

	// term product is added in the cycle after its unit letter
	always_comb begin
		if (pend_neg_q) begin
			sum = {total_q[TOTAL_W-1], total_q} - {2'b00, pend_prod_q};
		end else begin
			sum = {total_q[TOTAL_W-1], total_q} + {2'b00, pend_prod_q};
		end
		acc.ovf   = pend_q && (sum[TOTAL_W] != sum[TOTAL_W-1]);
		acc.total = (pend_q && !acc.ovf) ? sum[TOTAL_W-1:0] : total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			pend_q  <= 1'b0;
		end else if (clr) begin
			total_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			pend_q  <= req.vld;
			total_q <= acc.total;
		end
	end

	always_ff @(posedge clk) begin
		pend_neg_q  <= req.neg;
		pend_prod_q <= req.prod;
	end

endmodule

/* rtl/dtp_term.sv */
module dtp_term import dtp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic [7:0]   ch,
	input  dtp_acc_t     acc,
	output dtp_add_req_t req,
	output dtp_status_t  status
);

	dtp_phase_t          phase_q, phase_n;
	logic                neg_q, neg_n;
	logic [TERM_W-1:0]   term_q, term_n;
	dtp_status_t         err_q, err_n, err_eff;
	logic                is_digit, is_unit, scale_ovf, acc10_ovf;
	logic [3:0]          dval;
	logic [TERM_W+3:0]   acc10;
	logic [SCALE_W-1:0]  scale;
	logic [TERM_W-1:0]   lim;
	logic [TERM_W+SCALE_W-1:0] prod_w;

	always_comb begin
		err_eff   = (err_q != ST_OK) ? err_q : (acc.ovf ? ST_BOUNDS : ST_OK);
		is_digit  = (ch >= CH_0) && (ch <= CH_9);
		dval      = ch[3:0];
		acc10     = {1'b0, term_q, 3'b000} + {3'b000, term_q, 1'b0}
			+ {(TERM_W + 0)'(0), dval};
		acc10_ovf = |acc10[TERM_W+3:TERM_W];

		is_unit = 1'b1;
		case (ch)
			CH_M: begin scale = SCALE_M;     lim = LIM_M; end
			CH_H: begin scale = SCALE_H;     lim = LIM_H; end
			CH_D: begin scale = SCALE_D;     lim = LIM_D; end
			CH_W: begin scale = SCALE_W_MIN; lim = LIM_W; end
			default: begin
				scale   = SCALE_M;
				lim     = LIM_M;
				is_unit = 1'b0;
			end
		endcase
		prod_w    = (TERM_W+SCALE_W)'(term_q) * (TERM_W+SCALE_W)'(scale);
		scale_ovf = term_q > lim;

		phase_n  = phase_q;
		neg_n    = neg_q;
		term_n   = term_q;
		err_n    = err_eff;
		req.vld  = 1'b0;
		req.neg  = neg_q;
		req.prod = prod_w[TERM_W-1:0];

		if (err_eff != ST_OK) begin
			status = err_eff;
		end else begin
			case (phase_q)
				PH_START:  status = ST_EMPTY;
				PH_SIGN:   status = ST_DIGIT;
				PH_DIGITS: status = ST_UNIT;
				default:   status = ST_OK;
			endcase
		end

		if (take) begin
			if (ch == CH_NUL) begin
				phase_n = PH_START;
				neg_n   = 1'b0;
				term_n  = '0;
				err_n   = ST_OK;
			end else if (err_eff == ST_OK) begin
				case (phase_q)
					PH_START, PH_TERM: begin
						term_n = '0;
						neg_n  = 1'b0;
						if (ch == CH_PLUS || ch == CH_MINUS) begin
							neg_n   = (ch == CH_MINUS);
							phase_n = PH_SIGN;
						end else if (is_digit) begin
							term_n  = TERM_W'(dval);
							phase_n = PH_DIGITS;
						end else begin
							err_n = ST_DIGIT;
						end
					end
					PH_SIGN: begin
						if (is_digit) begin
							term_n  = TERM_W'(dval);
							phase_n = PH_DIGITS;
						end else begin
							err_n = ST_DIGIT;
						end
					end
					PH_DIGITS: begin
						if (is_digit) begin
							if (acc10_ovf) begin
								err_n = ST_BOUNDS;
							end else begin
								term_n = acc10[TERM_W-1:0];
							end
						end else if (!is_unit) begin
							err_n = ST_UNIT;
						end else if (scale_ovf) begin
							err_n = ST_BOUNDS;
						end else begin
							req.vld = 1'b1;
							phase_n = PH_TERM;
						end
					end
					default: begin
						phase_n = PH_START;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			term_q  <= '0;
			err_q   <= ST_OK;
		end else begin
			phase_q <= phase_n;
			neg_q   <= neg_n;
			term_q  <= term_n;
			err_q   <= err_n;
		end
	end

endmodule

/* rtl/duration_text_parser.sv */
// channel   dir  beat payload                      notes
// chars     in   ch[7:0]                          0 ends the string
// results   out  total_minutes[63:0], status[2:0]  one beat per terminator
//
// One character per cycle unless chars is stalled; the digit step, the unit
// scaling and the status are combinational; the running sum is added in the
// cycle after a unit letter. A result appears the cycle after its terminator
// and sits in an output register; chars is stalled only while that register
// holds an untaken beat. arst_n clears the parse state and output valid.
module duration_text_parser import dtp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	dtp_in_if.sink    chars,
	dtp_out_if.source results
);

	logic               take, term_end;
	dtp_add_req_t       req;
	dtp_acc_t           acc;
	dtp_status_t        status;
	logic               out_vld_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic [2:0]         out_status_q;

	assign chars.ready = !out_vld_q || results.ready;
	assign take        = chars.valid && chars.ready;
	assign term_end    = take && (chars.ch == CH_NUL);

	dtp_term u_term (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.ch     (chars.ch),
		.acc    (acc),
		.req    (req),
		.status (status)
	);

	dtp_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (term_end),
		.req    (req),
		.acc    (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (term_end) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (term_end) begin
			out_total_q  <= (status == ST_OK) ? acc.total : '0;
			out_status_q <= status;
		end
	end

	assign results.valid         = out_vld_q;
	assign results.total_minutes = out_total_q;
	assign results.status        = out_status_q;

endmodule

/* rtl/dtp_checker.sv */
`include "duration_text_parser_assert.svh"

module dtp_checker import dtp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  ch,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] total_minutes,
	input logic [2:0]  status
);

	`DTP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(total_minutes))
	`DTP_ASSERT_IMPLY(a_err_zero, clk, arst_n, out_valid && (status != ST_OK), total_minutes == 64'd0)
	`DTP_ASSERT_NEXT(a_term_beat, clk, arst_n, in_valid && in_ready && (ch == CH_NUL), out_valid)
	`DTP_ASSERT_NEXT(a_no_beat, clk, arst_n, in_valid && in_ready && (ch != CH_NUL) && (!out_valid || out_ready), !out_valid)

endmodule

bind duration_text_parser dtp_checker u_dtp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (chars.valid),
	.in_ready      (chars.ready),
	.ch            (chars.ch),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.total_minutes (results.total_minutes),
	.status        (results.status)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import dtp_pkg::*;

	localparam logic [63:0] U63_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;
	localparam int unsigned RANDOM_CHARS = 1680;

	typedef struct {
		logic [7:0]  ch;
		int unsigned gap;
		bit          hold;
	} char_beat_t;

	typedef struct {
		logic signed [63:0] total;
		dtp_status_t        status;
	} duration_t;

	logic clk;
	logic arst_n;

	dtp_in_if  chars_if ();
	dtp_out_if results_if ();

	duration_text_parser uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (results_if)
	);

	char_beat_t  char_stream[$];
	duration_t   pending_durations[$];
	logic [7:0]  word_q[$];
	int unsigned bad_beats;

	// parser state
	dtp_phase_t         ph;
	logic               neg;
	logic [62:0]        term;
	logic signed [63:0] sum;
	dtp_status_t        err;

	logic [7:0] unit_chars[4] = '{CH_M, CH_H, CH_D, CH_W};
	// per-unit limit with the last two digits dropped
	string limit_prefix[4] = '{"92233720368547758", "1537228672809129",
		"64051194700380", "9150170671482"};

	function automatic logic [63:0] unit_minutes(logic [7:0] c);
		case (c)
			CH_M: return 64'd1;
			CH_H: return 64'd60;
			CH_D: return 64'd1440;
			CH_W: return 64'd10080;
			default: return 64'd0;
		endcase
	endfunction

	task automatic clear_parse();
		ph = PH_START;
		neg = 1'b0;
		term = '0;
		sum = '0;
		err = ST_OK;
	endtask

	task automatic parse_char(input logic [7:0] c);
		logic               is_digit;
		logic [63:0]        d;
		logic [63:0]        scale;
		logic signed [63:0] p;
		duration_t          r;
		is_digit = (c >= CH_0) && (c <= CH_9);
		d = 64'(c - CH_0);
		if (c == CH_NUL) begin
			if (err != ST_OK)
				r.status = err;
			else if (ph == PH_START)
				r.status = ST_EMPTY;
			else if (ph == PH_SIGN)
				r.status = ST_DIGIT;
			else if (ph == PH_DIGITS)
				r.status = ST_UNIT;
			else
				r.status = ST_OK;
			r.total = (r.status == ST_OK) ? sum : '0;
			pending_durations.push_back(r);
			clear_parse();
		end else if (err == ST_OK) begin
			case (ph)
				PH_START, PH_TERM: begin
					term = '0;
					neg = 1'b0;
					if (c == CH_PLUS || c == CH_MINUS) begin
						neg = (c == CH_MINUS);
						ph = PH_SIGN;
					end else if (is_digit) begin
						term = 63'(d);
						ph = PH_DIGITS;
					end else begin
						err = ST_DIGIT;
					end
				end
				PH_SIGN: begin
					if (is_digit) begin
						term = 63'(d);
						ph = PH_DIGITS;
					end else begin
						err = ST_DIGIT;
					end
				end
				default: begin
					if (is_digit) begin
						if ({1'b0, term} > (U63_MAX - d) / 64'd10)
							err = ST_BOUNDS;
						else
							term = 63'({1'b0, term} * 64'd10 + d);
					end else begin
						scale = unit_minutes(c);
						if (scale == 0) begin
							err = ST_UNIT;
						end else if ({1'b0, term} > U63_MAX / scale) begin
							err = ST_BOUNDS;
						end else begin
							p = signed'({1'b0, term} * scale);
							if (!neg && sum > SUM_MAX - p)
								err = ST_BOUNDS;
							else if (neg && sum < SUM_MIN + p)
								err = ST_BOUNDS;
							else begin
								sum = neg ? sum - p : sum + p;
								ph = PH_TERM;
							end
						end
					end
				end
			endcase
		end
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			word_q.push_back(s[i]);
	endtask

	task automatic flush_word(input bit hold);
		bit calm;
		char_beat_t b;
		calm = ($urandom_range(0, 3) == 0);
		word_q.push_back(CH_NUL);
		foreach (word_q[i]) begin
			b.ch = word_q[i];
			b.gap = calm ? 0 : $urandom_range(0, 13);
			b.hold = hold && (i == 0);
			char_stream.push_back(b);
		end
		word_q.delete();
	endtask

	task automatic make_random_text();
		int unsigned n;
		int unsigned len;
		int unsigned u;
		int unsigned pos;
		word_q.delete();
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(0, 8);
			repeat (n) word_q.push_back(8'($urandom_range(1, 255)));
		end else begin
			n = $urandom_range(1, 3);
			repeat (n) begin
				case ($urandom_range(0, 2))
					1: word_q.push_back(CH_PLUS);
					2: word_q.push_back(CH_MINUS);
					default: ;
				endcase
				u = $urandom_range(0, 3);
				len = $urandom_range(0, 9);
				if (len == 9) begin
					add_text(limit_prefix[u]);
					len = 2;
				end else if (len >= 7) begin
					len = $urandom_range(5, 19);
				end else begin
					len = $urandom_range(1, 4);
				end
				repeat (len) word_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
				word_q.push_back(unit_chars[u]);
			end
			if ($urandom_range(0, 4) == 0) begin
				pos = $urandom_range(0, word_q.size() - 1);
				case ($urandom_range(0, 2))
					0: word_q[pos] = 8'($urandom_range(1, 255));
					1: word_q.delete(pos);
					default: while (word_q.size() > pos) void'(word_q.pop_back());
				endcase
			end
		end
		flush_word($urandom_range(0, 39) == 0);
	endtask

	task automatic report_mismatch(input string what, input duration_t want);
		if (bad_beats < 10)
			$display("%0t %s: exp total=%0d status=%0d, got total=%0d status=%0d",
				$realtime, what, want.total, want.status,
				results_if.total_minutes, results_if.status);
		bad_beats++;
	endtask

	// character driver
	int unsigned idle_cnt;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_if.valid <= 1'b0;
			chars_if.ch <= CH_NUL;
			idle_cnt <= 0;
		end else begin
			if (chars_if.valid && chars_if.ready)
				parse_char(chars_if.ch);
			if (!chars_if.valid || chars_if.ready) begin
				if (char_stream.size() == 0 ||
						(char_stream[0].hold && pending_durations.size() != 0)) begin
					chars_if.valid <= 1'b0;
				end else if (idle_cnt < char_stream[0].gap) begin
					chars_if.valid <= 1'b0;
					idle_cnt <= idle_cnt + 1;
				end else begin
					chars_if.valid <= 1'b1;
					chars_if.ch <= char_stream[0].ch;
					void'(char_stream.pop_front());
					idle_cnt <= 0;
				end
			end
		end
	end

	// result monitor
	int unsigned stall_cnt;
	int unsigned stall_next;
	bit rx_calm;
	duration_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
			stall_cnt <= 0;
		end else begin
			stall_next = stall_cnt;
			if (results_if.valid && results_if.ready) begin
				if (pending_durations.size() == 0) begin
					want.total = '0;
					want.status = ST_OK;
					report_mismatch("unexpected beat", want);
				end else begin
					want = pending_durations.pop_front();
					if (want.total !== results_if.total_minutes ||
							want.status !== results_if.status)
						report_mismatch("mismatch", want);
				end
				if ($urandom_range(0, 15) == 0)
					rx_calm = !rx_calm;
				stall_next = rx_calm ? 0 : $urandom_range(0, 13);
			end
			if (stall_next != 0) begin
				results_if.ready <= 1'b0;
				stall_cnt <= stall_next - 1;
			end else begin
				results_if.ready <= 1'b1;
				stall_cnt <= 0;
			end
		end
	end

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		string directed[$];
		int unsigned base;
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.ch = CH_NUL;
		results_if.ready = 1'b0;
		bad_beats = 0;
		rx_calm = 1'b0;
		clear_parse();

		directed = '{"", "+", "-7", "x", "12q", "5m", "+3h-2d+1w", "0m", "-0w",
			"9223372036854775807m", "9223372036854775808m",
			"-9223372036854775807m-1m", "-9223372036854775807m-2m",
			"9223372036854775807m+1m", "153722867280912930h", "153722867280912931h",
			"915017067148291w", "915017067148292w", "6405119470038039d",
			"+-3m", "3m4", "1mzz+", "2h3x5m"};
		foreach (directed[i]) begin
			add_text(directed[i]);
			flush_word(i == 13);
		end
		// high characters at term start and after digits
		word_q.push_back(8'h80);
		flush_word(1'b0);
		add_text("4");
		word_q.push_back(8'hFF);
		flush_word(1'b0);

		base = char_stream.size();
		while (char_stream.size() < base + RANDOM_CHARS)
			make_random_text();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (char_stream.size() != 0 || chars_if.valid)
			@(posedge clk);
		while (pending_durations.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (bad_beats == 0 && pending_durations.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
